[rtl/repe_pkg.sv]
// ----------------------------------------------------------------------------
// repe_pkg
// Types and arithmetic helpers for the fp16 rotary embedding pipeline.
// ----------------------------------------------------------------------------
package repe_pkg;

  localparam int unsigned NumStages = 8;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;

  // unrounded value: p * 2**e
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               s;
    logic signed [9:0]  e;
    logic [34:0]        p;
  } raw_t;

  // normalized value: 1.f * 2**x, top 24 bits of sig = 1.f with its leading one, then guard, sticky
  typedef struct packed {
    logic               spec;
    logic [31:0]        sval;
    logic               s;
    logic               z;
    logic signed [9:0]  x;
    logic [25:0]        sig;
  } nrm_t;

  // aligned adder operands
  typedef struct packed {
    logic        spec;
    logic [31:0] sval;
    logic        s;
    logic        zs;
    logic        sub;
    logic [7:0]  e;
    logic [26:0] a;
    logic [26:0] b;
  } aln_t;

  function automatic raw_t mul_raw(logic [15:0] h, logic [31:0] f);
    raw_t              r;
    logic [4:0]        eh;
    logic [7:0]        ef;
    logic              a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic signed [9:0] ea, eb;
    logic [10:0]       ma;
    logic [23:0]       mb;
    eh = h[14:10];
    ef = f[30:23];
    a_nan  = (eh == 5'h1f) && (h[9:0] != '0);
    a_inf  = (eh == 5'h1f) && (h[9:0] == '0);
    a_zero = (eh == '0) && (h[9:0] == '0);
    b_nan  = (ef == 8'hff) && (f[22:0] != '0);
    b_inf  = (ef == 8'hff) && (f[22:0] == '0);
    b_zero = (ef == '0) && (f[22:0] == '0);
    ea = (eh == '0) ? -10'sd14 : $signed({5'b0, eh}) - 10'sd15;
    eb = (ef == '0) ? -10'sd126 : $signed({2'b0, ef}) - 10'sd127;
    ma = {eh != '0, h[9:0]};
    mb = {ef != '0, f[22:0]};
    r.s    = h[15] ^ f[31];
    r.e    = ea + eb - 10'sd33;
    r.p    = 35'(ma * mb);
    r.spec = a_nan | a_inf | b_nan | b_inf;
    if (a_nan) begin
      r.sval = {h[15], 8'hff, 1'b1, h[8:0], 13'b0};
    end else if (b_nan) begin
      r.sval = f | QuietBit;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      r.sval = DefaultNan;
    end else begin
      r.sval = {r.s, 8'hff, 23'b0};
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc35(logic [34:0] v);
    logic [5:0] lz;
    lz = 6'd35;
    for (int i = 0; i < 35; i++) begin
      if (v[i]) lz = 6'(34 - i);
    end
    return lz;
  endfunction

  function automatic nrm_t normalize(raw_t r);
    nrm_t        n;
    logic [5:0]  lz;
    logic [34:0] sh;
    lz = lzc35(r.p);
    sh = r.p << lz;
    n.spec = r.spec;
    n.sval = r.sval;
    n.s    = r.s;
    n.z    = (r.p == '0);
    n.x    = r.e + 10'sd34 - $signed({4'b0, lz});
    n.sig  = {sh[34:11], sh[10], |sh[9:0]};
    return n;
  endfunction

  function automatic logic [31:0] round32(nrm_t n);
    logic signed [9:0] d, t;
    logic [4:0]        dd;
    logic [52:0]       w;
    logic [25:0]       g;
    logic [7:0]        ef;
    logic              inc;
    logic [30:0]       res;
    d  = -10'sd126 - n.x;
    t  = n.x + 10'sd127;
    dd = (d > 10'sd27) ? 5'd27 : d[4:0];
    w  = {n.sig, 27'b0} >> dd;
    if (d > 10'sd0) begin
      g  = {w[52:28], |w[27:0]};
      ef = '0;
    end else begin
      g  = n.sig;
      ef = t[7:0];
    end
    inc = g[1] & (g[0] | g[2]);
    res = {ef, g[24:2]} + 31'(inc);
    if (n.spec) begin
      return n.sval;
    end else if (n.z) begin
      return {n.s, 31'b0};
    end else if (n.x > 10'sd127) begin
      return {n.s, 8'hff, 23'b0};
    end
    return {n.s, res};
  endfunction

  function automatic aln_t align(logic [31:0] fa, logic [31:0] fb);
    aln_t        r;
    logic        a_nan, a_inf, b_nan, b_inf;
    logic [31:0] bg, lt;
    logic [7:0]  eb, el;
    logic [8:0]  d;
    logic [4:0]  dd;
    logic [53:0] w;
    a_nan = (fa[30:23] == 8'hff) && (fa[22:0] != '0);
    a_inf = (fa[30:23] == 8'hff) && (fa[22:0] == '0);
    b_nan = (fb[30:23] == 8'hff) && (fb[22:0] != '0);
    b_inf = (fb[30:23] == 8'hff) && (fb[22:0] == '0);
    r.spec = a_nan | a_inf | b_nan | b_inf;
    if (a_nan) begin
      r.sval = fa | QuietBit;
    end else if (b_nan) begin
      r.sval = fb | QuietBit;
    end else if (a_inf && b_inf && (fa[31] != fb[31])) begin
      r.sval = DefaultNan;
    end else if (a_inf) begin
      r.sval = fa;
    end else begin
      r.sval = fb;
    end
    if (fb[30:0] > fa[30:0]) begin
      bg = fb;
      lt = fa;
    end else begin
      bg = fa;
      lt = fb;
    end
    eb = (bg[30:23] == '0) ? 8'd1 : bg[30:23];
    el = (lt[30:23] == '0) ? 8'd1 : lt[30:23];
    d  = {1'b0, eb} - {1'b0, el};
    dd = (d > 9'd27) ? 5'd27 : d[4:0];
    w  = {lt[30:23] != '0, lt[22:0], 3'b0, 27'b0} >> dd;
    r.s   = bg[31];
    r.zs  = fa[31] & fb[31];
    r.sub = fa[31] ^ fb[31];
    r.e   = eb;
    r.a   = {bg[30:23] != '0, bg[22:0], 3'b0};
    r.b   = {w[53:28], w[27] | (|w[26:0])};
    return r;
  endfunction

  function automatic raw_t addsum(aln_t a);
    raw_t        r;
    logic [27:0] sm;
    sm = a.sub ? ({1'b0, a.a} - {1'b0, a.b}) : ({1'b0, a.a} + {1'b0, a.b});
    r.spec = a.spec;
    r.sval = a.sval;
    r.s    = (sm == '0) ? a.zs : a.s;
    r.e    = $signed({2'b0, a.e}) - 10'sd160;
    r.p    = {sm, 7'b0};
    return r;
  endfunction

  function automatic logic [15:0] narrow(logic [31:0] b);
    logic        s;
    logic [7:0]  e, et;
    logic [22:0] m;
    logic [23:0] mm, r, rem, half;
    logic [4:0]  sh;
    logic [14:0] rn;
    logic        inc;
    s  = b[31];
    e  = b[30:23];
    m  = b[22:0];
    et = e - 8'd112;
    rn = {et[4:0], m[22:13]};
    inc = (m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && rn[0]);
    mm = {1'b1, m};
    sh = 5'(8'd126 - e);
    r    = mm >> sh;
    rem  = mm & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 5'd1);
    if (e == 8'hff) begin
      return (m != '0) ? {s, 5'h1f, m[22:13] | 10'h200} : {s, 15'h7c00};
    end else if (e >= 8'd143) begin
      return {s, 15'h7c00};
    end else if (e >= 8'd113) begin
      return {s, rn + 15'(inc)};
    end else if (e < 8'd102) begin
      return {s, 15'b0};
    end
    inc = (rem > half) || ((rem == half) && r[0]);
    return {s, r[14:0] + 15'(inc)};
  endfunction

endpackage

[rtl/rotary_embed_pair_fp16.sv]
// ----------------------------------------------------------------------------
// rotary_embed_pair_fp16
// Rotates one fp16 pair by an fp32 cosine/sine: each product and sum is
// rounded to fp32 (RNE, subnormals kept), results narrowed back to fp16.
// ----------------------------------------------------------------------------
// Eight-stage pipeline, one item per cycle while not stalled: four
// 11x24 multipliers, product normalize, product round, operand align,
// add, sum normalize, sum round, narrow to fp16. A stall on the output
// holds the whole pipeline; empty stages are not squeezed out.
module rotary_embed_pair_fp16 import repe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] x_even_i,
  input  logic [15:0] x_odd_i,
  input  logic [31:0] cos_val_i,
  input  logic [31:0] sin_val_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] y_even_o,
  output logic [15:0] y_odd_o
);

  logic                 en;
  logic [NumStages-1:0] vld_q, vld_d;
  raw_t                 mr_q [4];
  nrm_t                 mn_q [4];
  logic [31:0]          pr_q [4];
  aln_t                 al_q [2];
  raw_t                 ar_q [2];
  nrm_t                 an_q [2];
  logic [31:0]          sr_q [2];
  logic [15:0]          y_q  [2];
  logic [31:0]          sub_b;

  assign en         = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[NumStages-2:0], in_valid_i};

  // subtrahend: flip sign unless NaN
  assign sub_b = ((pr_q[1][30:23] == 8'hff) && (pr_q[1][22:0] != '0)) ?
                 pr_q[1] : {~pr_q[1][31], pr_q[1][30:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mr_q[0] <= mul_raw(x_even_i, cos_val_i);
      mr_q[1] <= mul_raw(x_odd_i,  sin_val_i);
      mr_q[2] <= mul_raw(x_even_i, sin_val_i);
      mr_q[3] <= mul_raw(x_odd_i,  cos_val_i);
      for (int i = 0; i < 4; i++) begin
        mn_q[i] <= normalize(mr_q[i]);
        pr_q[i] <= round32(mn_q[i]);
      end
      al_q[0] <= align(pr_q[0], sub_b);
      al_q[1] <= align(pr_q[2], pr_q[3]);
      for (int i = 0; i < 2; i++) begin
        ar_q[i] <= addsum(al_q[i]);
        an_q[i] <= normalize(ar_q[i]);
        sr_q[i] <= round32(an_q[i]);
        y_q[i]  <= narrow(sr_q[i]);
      end
    end
  end

  assign out_valid_o = vld_q[NumStages-1];
  assign y_even_o    = y_q[0];
  assign y_odd_o     = y_q[1];

  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item lost at first stage");

  a_nan_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (y_even_o[14:10] == 5'h1f) && (y_even_o[9:0] != '0)) |-> y_even_o[9])
    else $error("y_even NaN not quiet");

  a_nan_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (y_odd_o[14:10] == 5'h1f) && (y_odd_o[9:0] != '0)) |-> y_odd_o[9])
    else $error("y_odd NaN not quiet");

endmodule
